FILE: rtl/rgb_to_rgbw_calibrated_macros.svh
// Assertion macros used by the checker file of rgb_to_rgbw_calibrated.
// No dependencies; pulled in by `include where assertions are written.
`ifndef RGB_TO_RGBW_CALIBRATED_MACROS_SVH
`define RGB_TO_RGBW_CALIBRATED_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rtw_pkg.sv
// Types, constants and arithmetic helpers for rgb_to_rgbw_calibrated.
// No dependencies; used by every module of the block by scoped names.
package rtw_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] gain;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } coef_t;

  localparam int unsigned REG_IDX_W = 3;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_WHITE_GAIN = 3'd0;
  localparam reg_idx_t REG_RED_COEF   = 3'd1;
  localparam reg_idx_t REG_GREEN_COEF = 3'd2;
  localparam reg_idx_t REG_BLUE_COEF  = 3'd3;

  localparam logic [7:0]  GAIN_RESET = 8'hFF;
  localparam logic [7:0]  COEF_RESET = 8'hA0;
  localparam logic [15:0] HALF_SCALE = 16'd127;

  // floor((p + 127) / 255) for p = k*v with 8-bit k, v.
  // x / 255 == (x + (x >> 8) + 1) >> 8, exact for x < 2^16 - 1.
  function automatic logic [7:0] scale_div(input logic [15:0] p);
    logic [15:0] x;
    logic [16:0] s;
    x = p + HALF_SCALE;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: rtl/rtw_front.sv
// White base extraction: multiply stage, then divide-by-255 and minimum stage.
// Depends on rtw_pkg.
module rtw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtw_pkg::pix_t in_pix,
  input  rtw_pkg::coef_t coef,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_w0,
  output rtw_pkg::pix_t out_pix
);

  logic          v1, v2;
  logic          en1, en2;
  logic [15:0]   p_red, p_green, p_blue;
  rtw_pkg::pix_t pix1, pix2;
  logic [7:0]    w0;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p_red   <= {8'b0, coef.red}   * {8'b0, in_pix.red};
      p_green <= {8'b0, coef.green} * {8'b0, in_pix.green};
      p_blue  <= {8'b0, coef.blue}  * {8'b0, in_pix.blue};
      pix1    <= in_pix;
    end
  end

  // stage 2: rounding divide and minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      w0   <= rtw_pkg::min2(rtw_pkg::scale_div(p_red),
                            rtw_pkg::min2(rtw_pkg::scale_div(p_green),
                                          rtw_pkg::scale_div(p_blue)));
      pix2 <= pix1;
    end
  end

  assign out_valid = v2;
  assign out_w0    = w0;
  assign out_pix   = pix2;

endmodule

FILE: rtl/rtw_back.sv
// White share removal: multiply stage, then divide-by-255 and subtract stage.
// Depends on rtw_pkg.
module rtw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_w0,
  input  rtw_pkg::pix_t  in_pix,
  input  rtw_pkg::coef_t coef,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     red_out,
  output logic [7:0]     green_out,
  output logic [7:0]     blue_out,
  output logic [7:0]     white_out
);

  logic          v3, v4;
  logic          en3, en4;
  logic [15:0]   q_red, q_green, q_blue, q_gain;
  rtw_pkg::pix_t pix3;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  // stage 3: products of the white base
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      q_red   <= {8'b0, coef.red}   * {8'b0, in_w0};
      q_green <= {8'b0, coef.green} * {8'b0, in_w0};
      q_blue  <= {8'b0, coef.blue}  * {8'b0, in_w0};
      q_gain  <= {8'b0, coef.gain}  * {8'b0, in_w0};
      pix3    <= in_pix;
    end
  end

  // stage 4: output register; t_k(w0) <= w0 <= channel, so no underflow
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      red_out   <= pix3.red   - rtw_pkg::scale_div(q_red);
      green_out <= pix3.green - rtw_pkg::scale_div(q_green);
      blue_out  <= pix3.blue  - rtw_pkg::scale_div(q_blue);
      white_out <= rtw_pkg::scale_div(q_gain);
    end
  end

  assign out_valid = v4;

endmodule

FILE: rtl/rgb_to_rgbw_calibrated.sv
// Top level of the calibrated RGB to RGBW converter: config registers and
// the two pipeline halves. Depends on rtw_pkg, rtw_front and rtw_back.
//
// Usage:
//  - Input channel in_valid/in_ready carries one RGB pixel per transaction
//    (red_in, green_in, blue_in). Output channel out_valid/out_ready carries
//    one RGBW pixel per transaction (red_out, green_out, blue_out, white_out).
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 white_gain, 1 red_coef, 2 green_coef, 3 blue_coef); other indexes
//    are ignored. Write only while the pipeline is empty.
//  - Path: an input transaction passes four register stages (multiply,
//    divide/min, multiply, divide/subtract) to out_valid, each stage with
//    its own valid bit. Throughput: one pixel per cycle while out_ready is high.
//  - Stall: each stage advances when it is empty or the next one advances,
//    so bubbles close up while out_ready is low; the block keeps taking
//    pixels until all four stages hold one. The output register holds
//    its transaction stable until taken.
//  - Reset (rst, synchronous, active high): all valid bits clear, the
//    gain returns to 255 and the three coefficients to 160.
module rgb_to_rgbw_calibrated (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  rtw_pkg::reg_idx_t     cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out,
  output logic [7:0]            white_out
);

  rtw_pkg::coef_t coef;
  rtw_pkg::pix_t  in_pix;
  rtw_pkg::pix_t  mid_pix;
  logic [7:0]     mid_w0;
  logic           mid_valid;
  logic           mid_ready;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.gain  <= rtw_pkg::GAIN_RESET;
      coef.red   <= rtw_pkg::COEF_RESET;
      coef.green <= rtw_pkg::COEF_RESET;
      coef.blue  <= rtw_pkg::COEF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtw_pkg::REG_WHITE_GAIN: coef.gain  <= cfg_data;
        rtw_pkg::REG_RED_COEF:   coef.red   <= cfg_data;
        rtw_pkg::REG_GREEN_COEF: coef.green <= cfg_data;
        rtw_pkg::REG_BLUE_COEF:  coef.blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_pix.red   = red_in;
  assign in_pix.green = green_in;
  assign in_pix.blue  = blue_in;

  // Stages 1-2: w0 = min of the three scaled channels
  rtw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (in_pix),
    .coef      (coef),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_w0    (mid_w0),
    .out_pix   (mid_pix)
  );

  // Stages 3-4: remove white share, scale white drive
  rtw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_w0     (mid_w0),
    .in_pix    (mid_pix),
    .coef      (coef),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .white_out (white_out)
  );

endmodule

FILE: rtl/rtw_checker.sv
// Port-level checker for rgb_to_rgbw_calibrated, bound to the top level.
// Depends on rgb_to_rgbw_calibrated_macros.svh.
`include "rgb_to_rgbw_calibrated_macros.svh"

module rtw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] white_out
);

  // transactions in flight: four stages at most
  logic [2:0] inflight;
  logic [2:0] inflight_next;

  always_comb begin
    inflight_next = inflight;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      inflight_next = inflight + 3'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      inflight_next = inflight - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `RTW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable({red_out, green_out, blue_out, white_out}),
    "stalled output changed")
  `RTW_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !out_valid,
    "output valid right after reset")
  `RTW_ASSERT_IMP(a_backpressure, clk, rst, !in_ready, out_valid && !out_ready,
    "input stalled without output stall")
  `RTW_ASSERT_IMP(a_occupancy, clk, rst, out_valid || !in_ready,
    (inflight != 3'd0) && (inflight <= 3'd4), "pipeline occupancy out of range")

endmodule

bind rgb_to_rgbw_calibrated rtw_checker u_rtw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .white_out (white_out)
);
